// File: rtl/sfcd_pkg.sv
package sfcd_pkg;

    localparam logic [7:0] SFCD_CRC_POLY = 8'h31;
    localparam logic [7:0] SFCD_CRC_INIT = 8'hFF;

    localparam logic [2:0] POS_TMSB = 3'd0;
    localparam logic [2:0] POS_TLSB = 3'd1;
    localparam logic [2:0] POS_TCRC = 3'd2;
    localparam logic [2:0] POS_HMSB = 3'd3;
    localparam logic [2:0] POS_HLSB = 3'd4;
    localparam logic [2:0] POS_HCRC = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TEMP_FAIL = 2'd1;
    localparam logic [1:0] ST_HUM_FAIL  = 2'd2;

    localparam logic [30:0] SFCD_TEMP_SCALE  = 31'd17500;
    localparam logic [29:0] SFCD_HUM_SCALE   = 30'd10000;
    localparam logic [15:0] SFCD_TEMP_OFFSET = 16'd4500;

    localparam int SFCD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] humid_word;
        logic [1:0]  status;
    } t_frame;

    function automatic logic [7:0] sfcd_crc8(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ SFCD_CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // The true quotient is either p >> 16 or one more, so a single remainder check decides.
    function automatic logic [14:0] sfcd_div65535(input logic [30:0] p);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = p[30:16];
        rem = {1'b0, p[15:0]} + {2'b00, q0};
        return (rem >= 17'd65535) ? q0 + 15'd1 : q0;
    endfunction

endpackage

// File: rtl/sfcd_front.sv
module sfcd_front import sfcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    output logic       o_push,
    output t_frame     o_frame,
    input  logic       i_full
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_humid, n_humid;
    logic        r_temp_ok, n_temp_ok;
    logic [2:0]  w_pos;
    logic        w_accept;
    logic        w_humid_ok;

    assign o_ready    = !i_full;
    assign w_accept   = i_valid && o_ready;
    assign w_pos      = (i_frame_start || r_pos > POS_HCRC) ? POS_TMSB : r_pos;
    assign w_humid_ok = (r_crc == i_rx_byte);

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_temp    = r_temp;
        n_humid   = r_humid;
        n_temp_ok = r_temp_ok;
        if (w_accept) begin
            n_pos = (w_pos == POS_HCRC) ? POS_TMSB : w_pos + 3'd1;
            unique case (w_pos)
                POS_TMSB: begin
                    n_crc  = sfcd_crc8(SFCD_CRC_INIT, i_rx_byte);
                    n_temp = {i_rx_byte, r_temp[7:0]};
                end
                POS_TLSB: begin
                    n_crc  = sfcd_crc8(r_crc, i_rx_byte);
                    n_temp = {r_temp[15:8], i_rx_byte};
                end
                POS_TCRC: begin
                    n_temp_ok = (r_crc == i_rx_byte);
                    n_crc     = SFCD_CRC_INIT;
                end
                POS_HMSB: begin
                    n_crc   = sfcd_crc8(SFCD_CRC_INIT, i_rx_byte);
                    n_humid = {i_rx_byte, r_humid[7:0]};
                end
                POS_HLSB: begin
                    n_crc   = sfcd_crc8(r_crc, i_rx_byte);
                    n_humid = {r_humid[15:8], i_rx_byte};
                end
                default: begin
                    n_crc = SFCD_CRC_INIT;
                end
            endcase
        end
    end

    always_comb begin
        o_push             = w_accept && (w_pos == POS_HCRC);
        o_frame.temp_word  = r_temp;
        o_frame.humid_word = r_humid;
        priority if (!r_temp_ok) begin
            o_frame.status = ST_TEMP_FAIL;
        end else if (!w_humid_ok) begin
            o_frame.status = ST_HUM_FAIL;
        end else begin
            o_frame.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_TMSB;
            r_crc     <= SFCD_CRC_INIT;
            r_temp_ok <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_temp_ok <= n_temp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp  <= n_temp;
        r_humid <= n_humid;
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_HCRC)
        else $error("byte position out of frame");

endmodule

// File: rtl/sfcd_fifo.sv
module sfcd_fifo import sfcd_pkg::*; #(
    parameter int P_DEPTH = SFCD_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_frame o_data,
    output logic   o_empty
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_frame          r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push, w_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_DEPTH))
        else $error("queue count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count missed a push");

endmodule

// File: rtl/sfcd_back.sv
module sfcd_back import sfcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_frame             i_frame,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_temperature_centideg,
    output logic [13:0]        o_humidity_centipct,
    output logic [1:0]         o_status
);

    logic               r_s1_valid;
    logic [30:0]        r_s1_tprod;
    logic [29:0]        r_s1_hprod;
    logic [1:0]         r_s1_status;
    logic               r_out_valid;
    logic signed [14:0] r_out_temp;
    logic [13:0]        r_out_hum;
    logic [1:0]         r_out_status;
    logic               w_s2_ready;
    logic [14:0]        w_tq;
    logic [14:0]        w_hq;
    logic [15:0]        w_tc;

    assign w_s2_ready = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || w_s2_ready;

    assign w_tq = sfcd_div65535(r_s1_tprod);
    assign w_hq = sfcd_div65535({1'b0, r_s1_hprod});
    assign w_tc = {1'b0, w_tq} - SFCD_TEMP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_tprod  <= SFCD_TEMP_SCALE * {15'd0, i_frame.temp_word};
            r_s1_hprod  <= SFCD_HUM_SCALE * {14'd0, i_frame.humid_word};
            r_s1_status <= i_frame.status;
        end
        if (w_s2_ready && r_s1_valid) begin
            r_out_status <= r_s1_status;
            if (r_s1_status == ST_OK) begin
                r_out_temp <= $signed(w_tc[14:0]);
                r_out_hum  <= w_hq[13:0];
            end else begin
                r_out_temp <= '0;
                r_out_hum  <= '0;
            end
        end
    end

    assign o_valid                = r_out_valid;
    assign o_temperature_centideg = r_out_temp;
    assign o_humidity_centipct    = r_out_hum;
    assign o_status               = r_out_status;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_temp == '0 && r_out_hum == '0))
        else $error("failed frame carries nonzero values");

endmodule

// File: rtl/sensor_frame_crc_decoder_unit.sv
// Temperature and humidity frame decoder.
// Input channel (i_valid/o_ready): one received byte per beat, i_frame_start marks the
// first byte of a frame and restarts the byte position. A frame is six bytes: temperature
// word, its CRC-8, humidity word, its CRC-8, words sent MSB first.
// Output channel (o_valid/i_ready): one beat per complete frame with temperature in
// hundredths of a degree, humidity in hundredths of a percent and a status code.
// On a check failure both values are zero; a temperature failure takes precedence.
// Throughput is one byte per cycle while o_ready is high; the front end's CRC update is
// combinational. The sixth byte writes the frame into the queue; the scaling products
// are then registered, and the corrected quotients go into the output register.
// A queue between the front end and the scaling pipeline lets bytes keep flowing while a
// result waits; when the receiver stalls long enough for the queue to fill, o_ready drops.
// Reset clears the byte position, the queue and all valid flags; no frame is in flight.
module sensor_frame_crc_decoder_unit import sfcd_pkg::*; #(
    parameter int P_QUEUE_DEPTH = SFCD_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_temperature_centideg,
    output logic [13:0]        o_humidity_centipct,
    output logic [1:0]         o_status
);

    logic   w_push;
    logic   w_full;
    logic   w_empty;
    logic   w_pop;
    t_frame w_push_frame;
    t_frame w_pop_frame;

    sfcd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_push        (w_push),
        .o_frame       (w_push_frame),
        .i_full        (w_full)
    );

    sfcd_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_frame),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_frame),
        .o_empty (w_empty)
    );

    sfcd_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (!w_empty),
        .o_ready                (w_pop),
        .i_frame                (w_pop_frame),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_temperature_centideg (o_temperature_centideg),
        .o_humidity_centipct    (o_humidity_centipct),
        .o_status               (o_status)
    );

endmodule

// File: test/tb_sensor_frame_crc_decoder_unit.sv
module tb_sensor_frame_crc_decoder_unit;
    import sfcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_rx_beat;

    typedef struct {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic [1:0]         status;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_frame_start = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [14:0] o_temperature_centideg;
    logic [13:0]        o_humidity_centipct;
    logic [1:0]         o_status;

    t_rx_beat rx_q[$];
    t_reading reading_q[$];
    t_rx_beat next_beat;
    t_reading got_reading;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    bit rx_taken = 1'b0;

    logic [2:0]  dec_pos = POS_TMSB;
    logic [7:0]  dec_crc = SFCD_CRC_INIT;
    logic [15:0] dec_temp = 16'h0000;
    logic [15:0] dec_hum = 16'h0000;
    logic        dec_temp_ok = 1'b0;

    sensor_frame_crc_decoder_unit dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_rx_byte              (i_rx_byte),
        .i_frame_start          (i_frame_start),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_temperature_centideg (o_temperature_centideg),
        .o_humidity_centipct    (o_humidity_centipct),
        .o_status               (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ SFCD_CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] word);
        return crc8_update(crc8_update(SFCD_CRC_INIT, word[15:8]), word[7:0]);
    endfunction

    task automatic decode_byte(input logic [7:0] data, input logic start);
        logic [2:0]  pos;
        logic        hum_ok;
        t_reading    r;
        int unsigned scaled;
        int          centideg;
        pos = (start || dec_pos > POS_HCRC) ? POS_TMSB : dec_pos;
        case (pos)
            POS_TMSB: begin
                dec_crc = crc8_update(SFCD_CRC_INIT, data);
                dec_temp[15:8] = data;
            end
            POS_TLSB: begin
                dec_crc = crc8_update(dec_crc, data);
                dec_temp[7:0] = data;
            end
            POS_TCRC: begin
                dec_temp_ok = (dec_crc == data);
                dec_crc = SFCD_CRC_INIT;
            end
            POS_HMSB: begin
                dec_crc = crc8_update(SFCD_CRC_INIT, data);
                dec_hum[15:8] = data;
            end
            POS_HLSB: begin
                dec_crc = crc8_update(dec_crc, data);
                dec_hum[7:0] = data;
            end
            default: begin
                hum_ok = (dec_crc == data);
                dec_crc = SFCD_CRC_INIT;
                r.temp = '0;
                r.hum = '0;
                r.status = ST_OK;
                if (!dec_temp_ok) begin
                    r.status = ST_TEMP_FAIL;
                end else if (!hum_ok) begin
                    r.status = ST_HUM_FAIL;
                end else begin
                    scaled = (32'd17500 * {16'd0, dec_temp}) / 32'd65535;
                    centideg = int'(scaled) - 4500;
                    r.temp = centideg[14:0];
                    scaled = (32'd10000 * {16'd0, dec_hum}) / 32'd65535;
                    r.hum = scaled[13:0];
                end
                reading_q.push_back(r);
            end
        endcase
        dec_pos = (pos == POS_HCRC) ? POS_TMSB : pos + 3'd1;
    endtask

    task automatic push_byte(input logic [7:0] data, input logic start);
        t_rx_beat b;
        b.data = data;
        b.start = start;
        rx_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_frame(input logic [15:0] t, input logic [15:0] h, input logic start,
                              input bit t_ok, input bit h_ok);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = word_crc(t);
        h_crc = word_crc(h);
        if (!t_ok) begin
            t_crc = t_crc ^ (8'd1 << $urandom_range(7));
        end
        if (!h_ok) begin
            h_crc = h_crc ^ (8'd1 << $urandom_range(7));
        end
        push_byte(t[15:8], start);
        push_byte(t[7:0], 1'b0);
        push_byte(t_crc, 1'b0);
        push_byte(h[15:8], 1'b0);
        push_byte(h[7:0], 1'b0);
        push_byte(h_crc, 1'b0);
    endtask

    task automatic push_random(input int count);
        int          target;
        int          pick;
        int          len;
        logic [15:0] t;
        logic [15:0] h;
        logic [7:0]  prefix[6];
        target = bytes_queued + count;
        while (bytes_queued < target) begin
            pick = $urandom_range(99);
            t = 16'($urandom());
            h = 16'($urandom());
            if ($urandom_range(19) == 0) begin
                t = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            if ($urandom_range(19) == 0) begin
                h = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            if (pick < 75) begin
                push_frame(t, h, $urandom_range(99) < 80,
                           $urandom_range(99) < 85, $urandom_range(99) < 85);
            end else if (pick < 88) begin
                prefix = '{t[15:8], t[7:0], word_crc(t), h[15:8], h[7:0], word_crc(h)};
                len = $urandom_range(5, 1);
                for (int k = 0; k < len; k++) begin
                    push_byte(prefix[k], k == 0);
                end
            end else begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++) begin
                    push_byte(8'($urandom()), 1'($urandom()));
                end
            end
        end
    endtask

    task automatic wait_inputs_taken();
        while (bytes_accepted != bytes_queued) begin
            @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (!i_valid || rx_taken) begin
                if (rx_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = rx_q.pop_front();
                    i_valid <= 1'b1;
                    i_rx_byte <= next_beat.data;
                    i_frame_start <= next_beat.start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        rx_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                rx_taken = 1'b1;
                bytes_accepted++;
                decode_byte(i_rx_byte, i_frame_start);
            end
            if (o_valid && i_ready) begin
                if (reading_q.size() == 0) begin
                    $error("result beat with no reading pending: temp %0d hum %0d status %0d",
                           o_temperature_centideg, o_humidity_centipct, o_status);
                    mismatch_count++;
                end else begin
                    got_reading = reading_q.pop_front();
                    if (o_temperature_centideg !== got_reading.temp) begin
                        $error("temperature_centideg: expected %0d, got %0d",
                               got_reading.temp, o_temperature_centideg);
                        mismatch_count++;
                    end
                    if (o_humidity_centipct !== got_reading.hum) begin
                        $error("humidity_centipct: expected %0d, got %0d",
                               got_reading.hum, o_humidity_centipct);
                        mismatch_count++;
                    end
                    if (o_status !== got_reading.status) begin
                        $error("status: expected %0d, got %0d", got_reading.status, o_status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 81;
        push_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // Back-to-back frame with no start flag, position wraps on its own.
        push_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1);
        // Both words fail their check; the temperature failure wins.
        push_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b0);
        // A partial frame cut short by a new start flag gives no result.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(word_crc(16'hFF00), 1'b0);
        push_frame(16'h1234, 16'hABCD, 1'b1, 1'b1, 1'b0);
        push_random(310);
        wait_inputs_taken();

        send_idle_pct = 81;
        recv_idle_pct = 27;
        push_random(333);
        wait_inputs_taken();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(334);
        wait_inputs_taken();

        while (reading_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
